[src/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Width of the internal byte position counter
  localparam int POSITION_BITS = 32;
  // Width of the reported byte position field
  localparam int BYTE_POS_W    = 32;
  localparam int CODE_POINT_W  = 21;

  // Byte class masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_PAT   = 8'b1000_0000;
  localparam logic [7:0] CONT_BITS  = 8'b0011_1111;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_BITS = 8'b0001_1111;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_BITS = 8'b0000_1111;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_BITS = 8'b0000_0111;

  typedef enum logic [1:0] {
    ST_CODE_POINT = 2'd0,
    ST_BAD_CONT   = 2'd1,
    ST_BAD_LEAD   = 2'd2,
    ST_TRUNCATED  = 2'd3
  } u8d_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } u8d_in_t;

  typedef struct packed {
    u8d_status_t             status;
    logic [CODE_POINT_W-1:0] code_point;
    logic [BYTE_POS_W-1:0]   byte_position;
    logic                    end_mark;
  } u8d_out_t;

endpackage

[src/u8d_core.sv]
// ----------------------------------------------------------------------------
// u8d_core
// Sequence state and per-byte decode: pending count, accumulator and byte
// position. Produces at most one result for each accepted beat.
// ----------------------------------------------------------------------------
module u8d_core import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  u8d_in_t  beat,
  output logic     res_valid,
  output u8d_out_t res
);

  logic [1:0]               pending_r, pending_nxt;
  logic [CODE_POINT_W-1:0]  acc_r, acc_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic [7:0] b;
  logic       is_cont;

  assign b       = beat.data_byte;
  assign is_cont = (b & CONT_MASK) == CONT_PAT;

  // Decode one byte against the current sequence state
  always_comb begin
    pending_nxt       = pending_r;
    acc_nxt           = acc_r;
    pos_nxt           = pos_r + 1'b1;
    res_valid         = 1'b0;
    res.status        = ST_CODE_POINT;
    res.code_point    = '0;
    res.byte_position = BYTE_POS_W'(pos_r);
    res.end_mark      = beat.stream_end;

    if (pending_r != 2'd0) begin
      if (!is_cont) begin
        // Drop the byte and go idle
        pending_nxt = 2'd0;
        acc_nxt     = '0;
        res_valid   = 1'b1;
        res.status  = ST_BAD_CONT;
      end else begin
        acc_nxt     = {acc_r[CODE_POINT_W-7:0], b[5:0]};
        pending_nxt = pending_r - 1'b1;
        if (pending_r == 2'd1) begin
          res_valid      = 1'b1;
          res.code_point = {acc_r[CODE_POINT_W-7:0], b[5:0]};
          acc_nxt        = '0;
        end
      end
    end else begin
      priority if (!b[7]) begin
        res_valid      = 1'b1;
        res.code_point = CODE_POINT_W'(b);
      end else if ((b & LEAD2_MASK) == (LEAD2_MASK << 1)) begin
        acc_nxt     = CODE_POINT_W'(b & LEAD2_BITS);
        pending_nxt = 2'd1;
      end else if ((b & LEAD3_MASK) == (LEAD3_MASK << 1)) begin
        acc_nxt     = CODE_POINT_W'(b & LEAD3_BITS);
        pending_nxt = 2'd2;
      end else if ((b & LEAD4_MASK) == (LEAD4_MASK << 1)) begin
        acc_nxt     = CODE_POINT_W'(b & LEAD4_BITS);
        pending_nxt = 2'd3;
      end else begin
        res_valid  = 1'b1;
        res.status = ST_BAD_LEAD;
      end
    end

    // Close the stream: flag an unfinished sequence, restart position
    if (beat.stream_end) begin
      if (!res_valid && pending_nxt != 2'd0) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNCATED;
      end
      pending_nxt = 2'd0;
      acc_nxt     = '0;
      pos_nxt     = '0;
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      acc_r     <= '0;
      pos_r     <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // An end-of-stream beat leaves the decoder idle at position zero
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && beat.stream_end) |=> (pending_r == 2'd0 && pos_r == '0))
    else $error("decoder not idle after end of stream");

  // Truncation is only reported on the final beat
  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.status == ST_TRUNCATED) |-> beat.stream_end)
    else $error("truncation reported before end of stream");

  // Idle state holds an empty accumulator
  a_idle_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == 2'd0) |-> (acc_r == '0))
    else $error("accumulator not cleared while idle");

endmodule

[src/u8d_skid.sv]
// ----------------------------------------------------------------------------
// u8d_skid
// Two-slot output buffer: an output register plus a skid slot, so the
// input side keeps moving for one beat after the output side stalls.
// ----------------------------------------------------------------------------
module u8d_skid import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  u8d_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output u8d_out_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  u8d_out_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  u8d_out_t skid_data_r, skid_data_nxt;
  logic     out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Refill the output register from the skid slot first, then new results
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Skid slot only fills behind a waiting output beat
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds data while output is empty");

  // Nothing is pushed while the buffer is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("result pushed into full buffer");

endmodule

[src/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in, at most one code point or error out.
// ----------------------------------------------------------------------------
// The decoder takes one byte beat per clock while in_stall is low and
// reports each result from an output register, once the byte that completes
// it is taken. Bytes that only open or extend a sequence give no result. A
// two-slot output buffer sits in front of the result port: in_stall rises
// only once both slots hold beats. Errors (bad continuation, invalid lead,
// truncated at end of stream) carry the position of the offending byte;
// the position restarts at zero after each beat marked as end of stream.
module utf8_stream_decoder import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  u8d_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output u8d_out_t out_data
);

  logic     in_accept;
  logic     res_valid;
  u8d_out_t res;
  logic     buf_full;

  // Accept a byte whenever the output buffer has room
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  u8d_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .beat      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  u8d_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
